// ===== rtl/timed_event_queue_defines.svh =====
// Shared assertion macros for the timed event queue
`ifndef TIMED_EVENT_QUEUE_DEFINES_SVH
`define TIMED_EVENT_QUEUE_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define TEQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("timed_event_queue check failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define TEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("timed_event_queue check failed");

`endif

// ===== rtl/teq_pkg.sv =====
package teq_pkg;

    localparam int NumEvents = 32;
    localparam int TimeBits  = 63;
    localparam int IdBits    = 5;

    typedef logic [IdBits-1:0]   id_t;
    typedef logic [TimeBits-1:0] tm_t;

    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_EXEC   = 2'd2,
        OP_RESET  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_FIRED = 2'd0,
        KIND_WAKE  = 2'd1,
        KIND_IDLE  = 2'd2,
        KIND_SUM   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_UWALK,
        ST_IWALK,
        ST_XCHECK,
        ST_XOUT,
        ST_SUM,
        ST_OUT,
        ST_RESET
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input item
        logic walk_start;  // cur <= head, clear prev
        logic walk_step;   // prev <= cur, cur <= next
        logic do_unlink;   // splice out cur (== id)
        logic do_insert;   // link id before cur
        logic do_pop;      // pop head
        logic clear_all;   // reset cancels all
        logic emit;        // load output register
        kind_t kind;
        logic  last;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic id_ok;
        logic pend_id;
        logic empty;
        logic has;         // walk cursor valid
        logic cur_is_id;
        logic cur_lt_t;    // due[cur] < new time
        logic head_due;    // head due exactly now
        logic out_busy;
    } dp_sts_t;

endpackage

// ===== rtl/teq_dp.sv =====
module teq_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  teq_pkg::dp_cmd_t    cmd,
    output teq_pkg::dp_sts_t    sts,
    input  logic [1:0]          in_op,
    input  logic [4:0]          in_event_id,
    input  logic [61:0]         in_delay,
    input  logic [61:0]         in_now,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          out_kind,
    output logic [4:0]          out_fired_event,
    output logic [62:0]         out_wake_time,
    output logic [63:0]         out_next_delta,
    output logic                out_last
);
    // per-event link storage held in flops (read at walk cursor and head)
    teq_pkg::tm_t due_reg  [teq_pkg::NumEvents];
    teq_pkg::id_t link_reg [teq_pkg::NumEvents];
    logic [teq_pkg::NumEvents-1:0] nval_reg, pend_reg;
    teq_pkg::id_t head_reg, cur_reg, prev_reg;
    logic empty_reg, has_reg, hprev_reg;

    teq_pkg::op_t op_reg;
    teq_pkg::id_t id_reg;
    teq_pkg::tm_t now_reg, t_reg;
    logic ok_reg;

    logic vld_reg;
    logic [1:0] kind_reg;
    teq_pkg::id_t ev_reg;
    logic [62:0] wake_reg;
    logic [63:0] delta_reg;
    logic last_reg;

    teq_pkg::tm_t hd;
    logic [63:0] delta_c;

    assign hd = due_reg[head_reg];

    // summary delta
    always_comb begin
        if (empty_reg) begin
            delta_c = '1;
        end else if (hd < now_reg) begin
            delta_c = '0;
        end else begin
            delta_c = 64'(hd - now_reg);
        end
    end

    assign sts.op        = op_reg;
    assign sts.id_ok     = ok_reg;
    assign sts.pend_id   = pend_reg[id_reg];
    assign sts.empty     = empty_reg;
    assign sts.has       = has_reg;
    assign sts.cur_is_id = (cur_reg == id_reg);
    assign sts.cur_lt_t  = (due_reg[cur_reg] < t_reg);
    assign sts.head_due  = !empty_reg && (hd == now_reg);
    assign sts.out_busy  = vld_reg;

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= teq_pkg::op_t'(in_op);
            id_reg  <= in_event_id;
            ok_reg  <= (32'(in_event_id) < teq_pkg::NumEvents);
            now_reg <= teq_pkg::tm_t'(in_now);
            t_reg   <= teq_pkg::tm_t'({1'b0, in_now} + {1'b0, in_delay});
        end
    end

    // list state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= '0;
            nval_reg  <= '0;
            head_reg  <= '0;
            empty_reg <= 1'b1;
            has_reg   <= 1'b0;
            hprev_reg <= 1'b0;
            cur_reg   <= '0;
            prev_reg  <= '0;
        end else begin
            if (cmd.walk_start) begin
                cur_reg   <= head_reg;
                has_reg   <= !empty_reg;
                hprev_reg <= 1'b0;
            end
            if (cmd.walk_step) begin
                prev_reg  <= cur_reg;
                hprev_reg <= 1'b1;
                has_reg   <= nval_reg[cur_reg];
                cur_reg   <= link_reg[cur_reg];
            end
            if (cmd.do_unlink) begin
                pend_reg[id_reg] <= 1'b0;
                if (has_reg) begin
                    if (hprev_reg) begin
                        nval_reg[prev_reg] <= nval_reg[id_reg];
                        link_reg[prev_reg] <= link_reg[id_reg];
                    end else if (nval_reg[id_reg]) begin
                        head_reg <= link_reg[id_reg];
                    end else begin
                        empty_reg <= 1'b1;
                    end
                end
            end
            if (cmd.do_insert) begin
                if (hprev_reg) begin
                    nval_reg[prev_reg] <= 1'b1;
                    link_reg[prev_reg] <= id_reg;
                end else begin
                    head_reg <= id_reg;
                end
                nval_reg[id_reg] <= has_reg;
                link_reg[id_reg] <= has_reg ? cur_reg : '0;
                due_reg[id_reg]  <= t_reg;
                pend_reg[id_reg] <= 1'b1;
                empty_reg        <= 1'b0;
            end
            if (cmd.do_pop) begin
                if (nval_reg[head_reg]) begin
                    head_reg <= link_reg[head_reg];
                end else begin
                    empty_reg <= 1'b1;
                end
                pend_reg[head_reg] <= 1'b0;
                nval_reg[head_reg] <= 1'b0;
            end
            if (cmd.clear_all) begin
                pend_reg  <= '0;
                nval_reg  <= '0;
                head_reg  <= '0;
                empty_reg <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (cmd.emit) begin
            vld_reg <= 1'b1;
        end else if (out_ready) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            kind_reg  <= cmd.kind;
            last_reg  <= cmd.last;
            ev_reg    <= (cmd.kind == teq_pkg::KIND_FIRED) ? head_reg : '0;
            wake_reg  <= (cmd.kind == teq_pkg::KIND_WAKE) ? 63'(t_reg) : '0;
            delta_reg <= (cmd.kind == teq_pkg::KIND_SUM) ? delta_c : '0;
        end
    end

    assign out_valid       = vld_reg;
    assign out_kind        = kind_reg;
    assign out_fired_event = ev_reg;
    assign out_wake_time   = wake_reg;
    assign out_next_delta  = delta_reg;
    assign out_last        = last_reg;
endmodule

// ===== rtl/teq_ctrl.sv =====
`include "timed_event_queue_defines.svh"
module teq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  teq_pkg::dp_sts_t  sts,
    output teq_pkg::dp_cmd_t  cmd
);
    teq_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= teq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.kind   = teq_pkg::KIND_SUM;
        in_ready   = 1'b0;
        case (state_reg)
            teq_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = teq_pkg::ST_DECODE;
                end
            end
            teq_pkg::ST_DECODE: begin
                cmd.walk_start = 1'b1;
                case (sts.op)
                    teq_pkg::OP_ENQ: begin
                        if (!sts.id_ok) state_next = teq_pkg::ST_IDLE;
                        else if (sts.pend_id) state_next = teq_pkg::ST_UWALK;
                        else state_next = teq_pkg::ST_IWALK;
                    end
                    teq_pkg::OP_CANCEL: begin
                        if (!sts.id_ok || !sts.pend_id) state_next = teq_pkg::ST_IDLE;
                        else state_next = teq_pkg::ST_UWALK;
                    end
                    teq_pkg::OP_EXEC:  state_next = teq_pkg::ST_XCHECK;
                    default:           state_next = teq_pkg::ST_RESET;
                endcase
            end
            // find the event, then splice it out
            teq_pkg::ST_UWALK: begin
                if (!sts.has || sts.cur_is_id) begin
                    cmd.do_unlink = 1'b1;
                    if (sts.op == teq_pkg::OP_ENQ) begin
                        state_next = teq_pkg::ST_DECODE;
                    end else begin
                        state_next = teq_pkg::ST_OUT;
                    end
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            // walk past earlier due times, then link in
            teq_pkg::ST_IWALK: begin
                if (sts.has && sts.cur_lt_t) begin
                    cmd.walk_step = 1'b1;
                end else begin
                    cmd.do_insert = 1'b1;
                    state_next    = teq_pkg::ST_OUT;
                end
            end
            teq_pkg::ST_XCHECK: begin
                if (!sts.out_busy) begin
                    state_next = sts.head_due ? teq_pkg::ST_XOUT : teq_pkg::ST_SUM;
                end
            end
            teq_pkg::ST_XOUT: begin
                cmd.emit   = 1'b1;
                cmd.kind   = teq_pkg::KIND_FIRED;
                cmd.do_pop = 1'b1;
                state_next = teq_pkg::ST_XCHECK;
            end
            teq_pkg::ST_SUM: begin
                cmd.emit   = 1'b1;
                cmd.kind   = teq_pkg::KIND_SUM;
                cmd.last   = 1'b1;
                state_next = teq_pkg::ST_IDLE;
            end
            // finish for enqueue (wake result) and cancel (idle result only if now empty)
            teq_pkg::ST_OUT: begin
                if (!sts.out_busy) begin
                    state_next = teq_pkg::ST_IDLE;
                    if (sts.op == teq_pkg::OP_ENQ) begin
                        cmd.emit = 1'b1;
                        cmd.kind = teq_pkg::KIND_WAKE;
                        cmd.last = 1'b1;
                    end else if (sts.empty) begin
                        cmd.emit = 1'b1;
                        cmd.kind = teq_pkg::KIND_IDLE;
                        cmd.last = 1'b1;
                    end
                end
            end
            teq_pkg::ST_RESET: begin
                if (!sts.out_busy) begin
                    cmd.clear_all = 1'b1;
                    state_next    = teq_pkg::ST_IDLE;
                    if (!sts.empty) begin
                        cmd.emit = 1'b1;
                        cmd.kind = teq_pkg::KIND_IDLE;
                        cmd.last = 1'b1;
                    end
                end
            end
            default: state_next = teq_pkg::ST_IDLE;
        endcase
    end

    `TEQ_ASSERT_IMPL(a_emit_free, cmd.emit, !sts.out_busy)
    `TEQ_ASSERT_IMPL(a_one_edit, cmd.do_insert, !cmd.do_unlink && !cmd.do_pop)
    `TEQ_ASSERT_NEXT(a_insert_fills, cmd.do_insert, !sts.empty)
    `TEQ_ASSERT_IMPL(a_pop_due, cmd.do_pop, sts.head_due)
endmodule

// ===== rtl/timed_event_queue.sv =====
// Sorted event queue for up to 32 numbered events. Each input transfer carries
// op in tuser and event_id, delay and now in tdata; the block answers with zero
// or more result transfers, kind in tuser, the final one flagged by tlast.
// Items are handled one at a time. Enqueue of a new event walks the list to
// its insert point (one list node per cycle); re-enqueue of a pending event
// first walks the list to unlink it; cancel walks to unlink; execute pops each
// fired event, then gives a summary; reset clears the list. Output stalls can
// hold the block. The walks are limited by the single link cursor in the
// datapath.
module timed_event_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [1:0] op
    input  logic [1:0]   s_tuser,
    // [4:0] event_id, [66:5] delay, [128:67] now
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] kind
    output logic [1:0]   m_tuser,
    // [4:0] fired_event, [67:5] wake_time, [131:68] next_delta
    output logic [135:0] m_tdata,
    output logic         m_tlast
);
    teq_pkg::dp_cmd_t cmd;
    teq_pkg::dp_sts_t sts;
    logic [4:0]  ev;
    logic [62:0] wake;
    logic [63:0] delta;

    teq_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .sts(sts), .cmd(cmd)
    );

    teq_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .in_op(s_tuser), .in_event_id(s_tdata[4:0]),
        .in_delay(s_tdata[66:5]), .in_now(s_tdata[128:67]),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_kind(m_tuser), .out_fired_event(ev), .out_wake_time(wake),
        .out_next_delta(delta), .out_last(m_tlast)
    );

    assign m_tdata = {4'b0000, delta, wake, ev};
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    typedef struct {
        teq_pkg::op_t op;
        teq_pkg::id_t id;
        logic [61:0]  delay;
        logic [61:0]  now;
        bit           drain;   // hold until all results are back
    } sched_item_t;

    typedef struct {
        teq_pkg::kind_t kind;
        teq_pkg::id_t   ev;
        logic [62:0]    wake;
        logic [63:0]    delta;
        logic           last;
    } sched_result_t;

    localparam logic [61:0] MaxTime = {62{1'b1}};

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [1:0]   s_tuser;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [1:0]   m_tuser;
    logic [135:0] m_tdata;
    logic         m_tlast;

    timed_event_queue dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    sched_item_t   items_todo[$];
    sched_result_t results_due[$];
    sched_item_t   cur_item;
    int            total_items = 0;
    int            items_sent;
    int            errors;
    bit            transfer_done;
    bit            gen_done;

    // Queue model: event ids in list order plus per-event due time
    logic [62:0] ev_due[teq_pkg::NumEvents];
    bit          ev_pend[teq_pkg::NumEvents];
    int          ev_order[$];

    // Generator-side view of pending due times, used to pick exec times
    logic [62:0] gen_due[teq_pkg::NumEvents];
    bit          gen_pend[teq_pkg::NumEvents];
    logic [61:0] gen_now;

    function automatic sched_result_t mk(teq_pkg::kind_t k, teq_pkg::id_t e,
                                         logic [62:0] w, logic [63:0] d, logic l);
        sched_result_t r;
        r.kind = k; r.ev = e; r.wake = w; r.delta = d; r.last = l;
        return r;
    endfunction

    function automatic void expect_result(sched_result_t r);
        results_due.insert(results_due.size(), r);
    endfunction

    function automatic void drop_event(int id);
        for (int i = 0; i < ev_order.size(); i++) begin
            if (ev_order[i] == id) begin
                ev_order.delete(i);
                break;
            end
        end
        ev_pend[id] = 0;
    endfunction

    // Compute the results one accepted item produces and update the model
    function automatic void predict_queue(sched_item_t it);
        logic [62:0] t;
        logic [62:0] nw;
        int          pos;
        int          h;
        nw = {1'b0, it.now};
        case (it.op)
            teq_pkg::OP_ENQ: begin
                t = nw + {1'b0, it.delay};
                if (ev_pend[it.id]) drop_event(it.id);
                pos = ev_order.size();
                for (int i = 0; i < ev_order.size(); i++) begin
                    if (ev_due[ev_order[i]] >= t) begin
                        pos = i;
                        break;
                    end
                end
                ev_order.insert(pos, it.id);
                ev_due[it.id] = t;
                ev_pend[it.id] = 1;
                expect_result(mk(teq_pkg::KIND_WAKE, '0, t, '0, 1'b1));
            end
            teq_pkg::OP_CANCEL: begin
                if (ev_pend[it.id]) begin
                    drop_event(it.id);
                    if (ev_order.size() == 0)
                        expect_result(mk(teq_pkg::KIND_IDLE, '0, '0, '0, 1'b1));
                end
            end
            teq_pkg::OP_EXEC: begin
                while (ev_order.size() > 0 && ev_due[ev_order[0]] == nw) begin
                    h = ev_order.pop_front();
                    ev_pend[h] = 0;
                    expect_result(mk(teq_pkg::KIND_FIRED, teq_pkg::id_t'(h), '0, '0, 1'b0));
                end
                if (ev_order.size() == 0)
                    expect_result(mk(teq_pkg::KIND_SUM, '0, '0, '1, 1'b1));
                else if (ev_due[ev_order[0]] < nw)
                    expect_result(mk(teq_pkg::KIND_SUM, '0, '0, '0, 1'b1));
                else
                    expect_result(mk(teq_pkg::KIND_SUM, '0, '0,
                        {1'b0, ev_due[ev_order[0]] - nw}, 1'b1));
            end
            default: begin
                if (ev_order.size() > 0)
                    expect_result(mk(teq_pkg::KIND_IDLE, '0, '0, '0, 1'b1));
                ev_order.delete();
                for (int i = 0; i < teq_pkg::NumEvents; i++) ev_pend[i] = 0;
            end
        endcase
    endfunction

    task automatic add_item(teq_pkg::op_t op, int id, logic [61:0] delay,
                            logic [61:0] now, bit drain = 0);
        sched_item_t it;
        it.op = op; it.id = teq_pkg::id_t'(id); it.delay = delay; it.now = now;
        it.drain = drain;
        items_todo.insert(items_todo.size(), it);
        // keep the generator view roughly in step
        case (op)
            teq_pkg::OP_ENQ: begin
                gen_pend[id] = 1;
                gen_due[id] = {1'b0, now} + {1'b0, delay};
            end
            teq_pkg::OP_CANCEL: gen_pend[id] = 0;
            teq_pkg::OP_EXEC: begin
                for (int i = 0; i < teq_pkg::NumEvents; i++)
                    if (gen_pend[i] && gen_due[i] == {1'b0, now}) gen_pend[i] = 0;
            end
            default: for (int i = 0; i < teq_pkg::NumEvents; i++) gen_pend[i] = 0;
        endcase
    endtask

    // Earliest pending due time not before the current time, else current time
    function automatic logic [61:0] next_fire_time();
        logic [62:0] best;
        best = '1;
        for (int i = 0; i < teq_pkg::NumEvents; i++)
            if (gen_pend[i] && gen_due[i] >= {1'b0, gen_now} && gen_due[i] < best)
                best = gen_due[i];
        if (best[62] || best == '1) return gen_now;
        return best[61:0];
    endfunction

    // Stimulus
    initial begin
        int r;
        logic [61:0] dl;
        gen_done = 0;
        gen_now = '0;
        for (int i = 0; i < teq_pkg::NumEvents; i++) gen_pend[i] = 0;

        // directed: empty-queue cases, tie ordering, re-enqueue, overdue head
        add_item(teq_pkg::OP_RESET, 0, 0, 0);
        add_item(teq_pkg::OP_EXEC, 0, 0, 0);
        add_item(teq_pkg::OP_CANCEL, 5, 0, 0);
        add_item(teq_pkg::OP_ENQ, 0, 5, 0);
        add_item(teq_pkg::OP_ENQ, 31, 5, 0);
        add_item(teq_pkg::OP_ENQ, 1, 3, 0);
        add_item(teq_pkg::OP_ENQ, 0, 10, 0);
        add_item(teq_pkg::OP_CANCEL, 1, 0, 1);
        add_item(teq_pkg::OP_EXEC, 0, 0, 5);
        add_item(teq_pkg::OP_EXEC, 0, 0, 5);
        add_item(teq_pkg::OP_EXEC, 0, 0, 10);
        add_item(teq_pkg::OP_ENQ, 2, 0, 10);
        add_item(teq_pkg::OP_EXEC, 0, 0, 10);
        add_item(teq_pkg::OP_ENQ, 3, 2, 10);
        add_item(teq_pkg::OP_CANCEL, 3, 0, 10);
        add_item(teq_pkg::OP_ENQ, 4, 1, 10, 1);
        add_item(teq_pkg::OP_EXEC, 0, 0, 12);
        add_item(teq_pkg::OP_RESET, 0, 0, 12);
        // all events due at once: the longest burst of fired results
        for (int i = 0; i < teq_pkg::NumEvents; i++)
            add_item(teq_pkg::OP_ENQ, i, 20 - 12, 12);
        add_item(teq_pkg::OP_EXEC, 0, 0, 20);
        gen_now = 20;

        // random: mostly short delays and exec at real due times
        for (int n = 0; n < 60; n++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                dl = ($urandom_range(9) == 0) ? 62'({$urandom(), $urandom()})
                                               : 62'($urandom_range(30));
                add_item(teq_pkg::OP_ENQ, $urandom_range(teq_pkg::NumEvents - 1), dl,
                         gen_now, n == 30);
            end else if (r < 62) begin
                add_item(teq_pkg::OP_CANCEL, $urandom_range(teq_pkg::NumEvents - 1),
                         62'($urandom()), gen_now);
            end else if (r < 96) begin
                if ($urandom_range(9) < 7) gen_now = next_fire_time();
                else gen_now = gen_now + 62'($urandom_range(6));
                add_item(teq_pkg::OP_EXEC, $urandom_range(teq_pkg::NumEvents - 1),
                         62'($urandom()), gen_now);
            end else begin
                add_item(teq_pkg::OP_RESET, $urandom_range(teq_pkg::NumEvents - 1),
                         62'($urandom()), gen_now);
            end
        end

        // wide times at the end, since time never goes back
        add_item(teq_pkg::OP_ENQ, 7, MaxTime, 62'h2AAA_AAAA_AAAA_AAAA);
        add_item(teq_pkg::OP_EXEC, 0, 0, 62'h2AAA_AAAA_AAAA_AAAA);
        add_item(teq_pkg::OP_ENQ, 8, 0, MaxTime);
        add_item(teq_pkg::OP_ENQ, 9, 62'h1555_5555_5555_5555, MaxTime);
        add_item(teq_pkg::OP_EXEC, 0, 0, MaxTime);
        add_item(teq_pkg::OP_RESET, 0, 0, MaxTime);
        total_items = items_todo.size();
        gen_done = 1;
    end

    // Idling phases follow progress through the item list
    int phase;
    int src_idle_pct;
    int snk_stall_pct;
    always_comb begin
        phase = (total_items > 0) ? (items_sent * 4) / total_items : 0;
        case (phase)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 66; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 66; end
            default: begin src_idle_pct = 17; snk_stall_pct = 17; end
        endcase
    end

    // Input transfer accepted: run the model
    always @(posedge aclk) begin
        transfer_done <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            predict_queue(cur_item);
            items_sent <= items_sent + 1;
        end
    end

    // Driver
    always @(negedge aclk) begin
        if (aresetn && gen_done) begin
            if (!s_tvalid || transfer_done) begin
                if (items_todo.size() > 0 && $urandom_range(99) >= src_idle_pct
                    && !(items_todo[0].drain && results_due.size() > 0)) begin
                    cur_item = items_todo.pop_front();
                    s_tuser <= cur_item.op;
                    s_tdata <= {7'd0, cur_item.now, cur_item.delay, cur_item.id};
                    s_tvalid <= 1;
                end else begin
                    s_tvalid <= 0;
                end
            end
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        sched_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $error("unexpected result transfer kind=%0d", m_tuser);
                errors++;
            end else begin
                e = results_due.pop_front();
                if (m_tuser !== e.kind) begin
                    $error("kind: expected %0d got %0d", e.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[4:0] !== e.ev) begin
                    $error("fired_event: expected %0d got %0d", e.ev, m_tdata[4:0]);
                    errors++;
                end
                if (m_tdata[67:5] !== e.wake) begin
                    $error("wake_time: expected %0h got %0h", e.wake, m_tdata[67:5]);
                    errors++;
                end
                if (m_tdata[131:68] !== e.delta) begin
                    $error("next_delta: expected %0h got %0h", e.delta, m_tdata[131:68]);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $error("last: expected %0d got %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Reset, then wait for everything to drain
    initial begin
        errors = 0;
        items_sent = 0;
        transfer_done = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tuser = '0;
        s_tdata = '0;
        m_tready = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        wait (gen_done);
        while (items_todo.size() > 0 || s_tvalid || results_due.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0 && results_due.size() == 0)
            $display("timed_event_queue test passed");
        else
            $display("timed_event_queue test failed");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("timed_event_queue test failed");
        $finish;
    end

endmodule
